[src/imh_pkg.sv]
package imh_pkg;

	// Default sizes of the heap
	localparam int CAPACITY_DEF      = 1024;
	localparam int PRIORITY_BITS_DEF = 30;
	localparam int TAG_BITS_DEF      = 10;

	// Fixed field widths on the channels
	localparam int HANDLE_BITS = 10;
	localparam int REQ_BITS    = 2;
	localparam int STATUS_BITS = 2;

	typedef enum logic [REQ_BITS-1:0] {
		REQ_CLEAR    = 2'd0,
		REQ_PUSH     = 2'd1,
		REQ_EXTRACT  = 2'd2,
		REQ_DECREASE = 2'd3
	} req_e_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOT_LIVE = 2'd3
	} status_e_t;

endpackage

[src/imh_ifs.sv]
interface imh_req_if #(
	parameter int PRIORITY_BITS = imh_pkg::PRIORITY_BITS_DEF,
	parameter int TAG_BITS      = imh_pkg::TAG_BITS_DEF
);
	import imh_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [REQ_BITS-1:0]      req_type;
	logic [HANDLE_BITS-1:0]   handle;
	logic [PRIORITY_BITS-1:0] priority_req;
	logic [TAG_BITS-1:0]      tag;

	modport source (output valid, req_type, handle, priority_req, tag, input ready);
	modport sink   (input valid, req_type, handle, priority_req, tag, output ready);
endinterface

interface imh_rsp_if #(
	parameter int PRIORITY_BITS = imh_pkg::PRIORITY_BITS_DEF,
	parameter int TAG_BITS      = imh_pkg::TAG_BITS_DEF
);
	import imh_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [STATUS_BITS-1:0]   status;
	logic [PRIORITY_BITS-1:0] out_priority;
	logic [TAG_BITS-1:0]      out_tag;
	logic [HANDLE_BITS-1:0]   out_handle;
	logic                     is_empty;

	modport source (output valid, status, out_priority, out_tag, out_handle, is_empty,
		input ready);
	modport sink   (input valid, status, out_priority, out_tag, out_handle, is_empty,
		output ready);
endinterface

[src/indexed_min_heap_decrease_key.sv]
// Channel | Dir | Payload
// req     | in  | req_type, handle, priority_req, tag
// rsp     | out | status, out_priority, out_tag, out_handle, is_empty
//
// One request at a time; clear, full push, empty extract and a decrease of an out-of-range
// handle go straight to the finish state, a dead decrease after its handle read. Push climbs
// one level per parent read and compare; decrease first reads the handle's slot, then climbs
// the same way. Extract reads the root and the last entry, then sinks one level per compare
// (both children read on the two slot ports); an extract of the last entry stops after that read.
// Reset needs no clearing pass. A result waits in the output register while rsp.ready is
// low; the next request is taken once that result has moved into the register.
module indexed_min_heap_decrease_key #(
	parameter int CAPACITY      = imh_pkg::CAPACITY_DEF,
	parameter int PRIORITY_BITS = imh_pkg::PRIORITY_BITS_DEF,
	parameter int TAG_BITS      = imh_pkg::TAG_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	imh_req_if.sink    req,
	imh_rsp_if.source  rsp
);
	import imh_pkg::*;

	localparam int HW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = HW + 1;
	localparam int XW = HW + HANDLE_BITS;

	typedef struct packed {
		logic [PRIORITY_BITS-1:0] pri;
		logic [TAG_BITS-1:0]      tag;
		logic [HW-1:0]            owner;
	} entry_t;

	typedef struct packed {
		logic          dead;
		logic [HW-1:0] slot;
	} hslot_t;

	typedef enum logic [2:0] {
		S_IDLE, S_UP, S_UP_CMP, S_DN, S_DN_CMP, S_EX_RD, S_DEC_RD, S_FIN
	} state_t;

	// Memories
	entry_t slot_mem [CAPACITY];
	hslot_t hslot_mem [CAPACITY];

	state_t state_q;
	logic [CW-1:0] count_q, issued_q;
	logic [HW-1:0] s_q;
	entry_t cur_q;
	logic [HANDLE_BITS-1:0] h_q;
	logic [PRIORITY_BITS-1:0] pri_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [STATUS_BITS-1:0] res_status_q;
	logic [PRIORITY_BITS-1:0] res_pri_q;
	logic [TAG_BITS-1:0] res_tag_q;
	logic [HANDLE_BITS-1:0] res_handle_q;

	logic ovalid_q;
	logic [STATUS_BITS-1:0] o_status_q;
	logic [PRIORITY_BITS-1:0] o_pri_q;
	logic [TAG_BITS-1:0] o_tag_q;
	logic [HANDLE_BITS-1:0] o_handle_q;
	logic o_empty_q;

	// Memory port signals
	logic [HW-1:0] ra_a, ra_b, hra;
	entry_t rd_a, rd_b;
	hslot_t hrd;
	logic sw_en, hw_en;
	logic [HW-1:0] sw_addr, hw_addr;
	entry_t sw_data;
	hslot_t hw_data;

	// Derived indexes
	logic [HW:0] l_idx, r_idx;
	logic [HW-1:0] parent;
	logic [XW-1:0] h_wide, in_h_wide, own_wide, iss_wide;
	logic l_in, r_in, pick_r, down_go, up_go, dec_live;
	entry_t best;

	assign l_idx    = {s_q, 1'b1};
	assign r_idx    = l_idx + (HW+1)'(1);
	assign parent   = (s_q - HW'(1)) >> 1;
	assign l_in     = l_idx < count_q;
	assign r_in     = r_idx < count_q;
	assign pick_r   = r_in && (rd_b.pri < rd_a.pri);
	assign best     = pick_r ? rd_b : rd_a;
	assign down_go  = best.pri < cur_q.pri;
	assign up_go    = cur_q.pri < rd_a.pri;
	assign h_wide   = {{HW{1'b0}}, h_q};
	assign in_h_wide = {{HW{1'b0}}, req.handle};
	assign own_wide = {{HANDLE_BITS{1'b0}}, rd_a.owner};
	assign iss_wide = {{(HANDLE_BITS-1){1'b0}}, issued_q};
	assign dec_live = (h_wide < iss_wide) && !hrd.dead && ({1'b0, hrd.slot} < count_q);

	// Drive memory addresses and write ports
	always_comb begin
		ra_a    = '0;
		ra_b    = '0;
		hra     = h_wide[HW-1:0];
		sw_en   = 1'b0;
		sw_addr = s_q;
		sw_data = cur_q;
		hw_en   = 1'b0;
		hw_addr = cur_q.owner;
		hw_data = '{dead: 1'b0, slot: s_q};
		unique case (state_q)
			S_IDLE: begin
				ra_b = HW'(count_q - CW'(1));
				hra  = in_h_wide[HW-1:0];
			end
			S_UP: begin
				ra_a = parent;
				if (s_q == '0) begin
					sw_en = 1'b1;
					hw_en = 1'b1;
				end
			end
			S_UP_CMP: begin
				sw_en = 1'b1;
				hw_en = 1'b1;
				if (up_go) begin
					sw_data = rd_a;
					hw_addr = rd_a.owner;
				end
			end
			S_DN: begin
				ra_a = l_idx[HW-1:0];
				ra_b = r_idx[HW-1:0];
				if (!l_in) begin
					sw_en = 1'b1;
					hw_en = 1'b1;
				end
			end
			S_DN_CMP: begin
				sw_en = 1'b1;
				hw_en = 1'b1;
				if (down_go) begin
					sw_data = best;
					hw_addr = best.owner;
				end
			end
			S_EX_RD: begin
				hw_en   = 1'b1;
				hw_addr = rd_a.owner;
				hw_data = '{dead: 1'b1, slot: '0};
			end
			S_DEC_RD, S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	// Slot memory: one write, two registered reads
	always_ff @(posedge clk) begin
		if (sw_en) slot_mem[sw_addr] <= sw_data;
		rd_a <= slot_mem[ra_a];
		rd_b <= slot_mem[ra_b];
	end

	// Handle-to-slot memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (hw_en) hslot_mem[hw_addr] <= hw_data;
		hrd <= hslot_mem[hra];
	end

	assign req.ready = (state_q == S_IDLE);

	// Sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			issued_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && rsp.ready && state_q != S_FIN) ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						h_q          <= req.handle;
						pri_q        <= req.priority_req;
						tag_q        <= req.tag;
						res_status_q <= ST_OK;
						res_pri_q    <= '0;
						res_tag_q    <= '0;
						res_handle_q <= '0;
						state_q      <= S_FIN;
						unique case (req_e_t'(req.req_type))
							REQ_CLEAR: begin
								count_q  <= '0;
								issued_q <= '0;
							end
							REQ_PUSH: begin
								if (count_q >= CW'(CAPACITY) || issued_q >= CW'(CAPACITY)) begin
									res_status_q <= ST_FULL;
								end else begin
									cur_q        <= '{pri: req.priority_req, tag: req.tag,
										owner: issued_q[HW-1:0]};
									s_q          <= count_q[HW-1:0];
									count_q      <= count_q + CW'(1);
									issued_q     <= issued_q + CW'(1);
									res_handle_q <= iss_wide[HANDLE_BITS-1:0];
									state_q      <= S_UP;
								end
							end
							REQ_EXTRACT: begin
								if (count_q == '0) res_status_q <= ST_EMPTY;
								else state_q <= S_EX_RD;
							end
							REQ_DECREASE: begin
								if (in_h_wide >= XW'(CAPACITY)) res_status_q <= ST_NOT_LIVE;
								else state_q <= S_DEC_RD;
							end
							default: begin
							end
						endcase
					end
				end
				S_EX_RD: begin
					res_pri_q    <= rd_a.pri;
					res_tag_q    <= rd_a.tag;
					res_handle_q <= own_wide[HANDLE_BITS-1:0];
					count_q      <= count_q - CW'(1);
					cur_q        <= rd_b;
					s_q          <= '0;
					state_q      <= (count_q == CW'(1)) ? S_FIN : S_DN;
				end
				S_DEC_RD: begin
					if (dec_live) begin
						cur_q   <= '{pri: pri_q, tag: tag_q, owner: h_wide[HW-1:0]};
						s_q     <= hrd.slot;
						state_q <= S_UP;
					end else begin
						res_status_q <= ST_NOT_LIVE;
						state_q      <= S_FIN;
					end
				end
				S_UP: begin
					state_q <= (s_q == '0) ? S_FIN : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (up_go) begin
						s_q     <= parent;
						state_q <= S_UP;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_DN: begin
					state_q <= l_in ? S_DN_CMP : S_FIN;
				end
				S_DN_CMP: begin
					if (down_go) begin
						s_q     <= pick_r ? r_idx[HW-1:0] : l_idx[HW-1:0];
						state_q <= S_DN;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!ovalid_q || rsp.ready) begin
						ovalid_q   <= 1'b1;
						o_status_q <= res_status_q;
						o_pri_q    <= res_pri_q;
						o_tag_q    <= res_tag_q;
						o_handle_q <= res_handle_q;
						o_empty_q  <= (count_q == '0);
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid        = ovalid_q;
	assign rsp.status       = o_status_q;
	assign rsp.out_priority = o_pri_q;
	assign rsp.out_tag      = o_tag_q;
	assign rsp.out_handle   = o_handle_q;
	assign rsp.is_empty     = o_empty_q;

	// Heap never holds more entries than handles issued, nor more than capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY)) else $error("entry count above capacity");
	a_count_issued: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= issued_q) else $error("entry count above handles issued");
	a_push_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && req.valid && req.req_type == REQ_PUSH
			&& count_q < CW'(CAPACITY) && issued_q < CW'(CAPACITY))
		|=> count_q == $past(count_q) + CW'(1)) else $error("push did not grow heap");
	a_fin_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && (!ovalid_q || rsp.ready))
		|=> rsp.valid && rsp.is_empty == (count_q == '0))
		else $error("empty flag disagrees with count");

endmodule
